/* hdl/assert_macros.svh */
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/mat4ci_pkg.sv */
// Types, constants and helpers for the 4x4 cofactor matrix inverse
package mat4ci_pkg;

    localparam int ElemW = 32;
    localparam int CofW  = 98;
    localparam int AccW  = 132;
    localparam int QW    = 33;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_TERM_A,
        ST_TERM_B,
        ST_MUL,
        ST_MUL_DONE,
        ST_DET_A,
        ST_DET_PREP,
        ST_K_INIT,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_DET
    } t_phase;

    // minor columns per term, packed {row2, row1, row0}
    localparam logic [5:0] TermCols [6] = '{
        {2'd2, 2'd1, 2'd0},
        {2'd1, 2'd2, 2'd0},
        {2'd2, 2'd0, 2'd1},
        {2'd0, 2'd2, 2'd1},
        {2'd1, 2'd0, 2'd2},
        {2'd0, 2'd1, 2'd2}
    };

    localparam logic [5:0] TermNeg = 6'b100110;

    function automatic logic [1:0] skip_idx(input logic [1:0] idx, input logic [1:0] excl);
        logic [1:0] res;
        res = (idx >= excl) ? idx + 2'd1 : idx;
        return res;
    endfunction

    function automatic logic [3:0] elem_addr(input logic [3:0] cidx, input logic [2:0] term,
                                             input logic [1:0] row);
        logic [5:0] cols;
        logic [1:0] col;
        cols = TermCols[term];
        col  = cols[{row, 1'b0} +: 2];
        return {skip_idx(row, cidx[3:2]), skip_idx(col, cidx[1:0])};
    endfunction

endpackage

/* hdl/mat4_cofactor_inverse.sv */
// Top level: 4x4 fixed-point matrix inverse by cofactors and long division
// Sixteen elements are taken one per cycle in row-major order; the sixteenth starts the
// work and the input stalls until all sixteen inverse elements have been taken. The
// products run through one shift-add multiplier (one bit per cycle) and the quotients through
// one restoring divider (one quotient bit per cycle) with a 133-bit remainder. Each of the 96
// triple products takes two multiplier passes, the determinant four, and each output element
// one division; each element is then held while the output is stalled. A zero determinant
// skips the division and every element comes out as 0 with the singular flag set.
module mat4_cofactor_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_element,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_inv_element,
    output logic        [3:0]  o_position,
    output logic               o_singular,
    output logic               o_saturated,
    output logic               o_last
);
    import mat4ci_pkg::*;

    localparam int NW   = CofW + 2 * FRAC_BITS;
    localparam int CntW = $clog2(NW);
    localparam int RemW = AccW + 1;

    t_state r_state, n_state;
    t_phase r_phase;

    logic [ElemW-1:0] r_mat [16];
    logic [CofW-1:0]  r_cof [16];
    logic [3:0]       r_cnt;
    logic [3:0]       r_cidx;
    logic [2:0]       r_term;
    logic [4:0]       r_bit;
    logic [AccW-1:0]  r_m;
    logic [AccW-1:0]  r_p;
    logic [ElemW-1:0] r_b;
    logic [AccW-1:0]  r_acc;
    logic [AccW-1:0]  r_dmag;
    logic             r_dneg;
    logic             r_sing;
    logic [NW-1:0]    r_num;
    logic [RemW-1:0]  r_rem;
    logic [QW-1:0]    r_q;
    logic             r_hi;
    logic             r_negr;
    logic [CntW-1:0]  r_dcnt;
    logic [31:0]      r_val;
    logic             r_sat;

    logic [3:0]       rd_addr;
    logic [3:0]       cof_addr;
    logic [ElemW-1:0] elem_rd;
    logic [CofW-1:0]  cof_rd;
    logic [AccW-1:0]  mul_add;
    logic [AccW-1:0]  p_next;
    logic             acc_neg;
    logic [AccW-1:0]  acc_next;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  rem_sub;
    logic             rem_ge;
    logic [CofW-1:0]  cof_mag;
    logic [31:0]      sat_limit;

    always_comb begin
        unique case (r_state)
            ST_TERM_A:   rd_addr = elem_addr(r_cidx, r_term, 2'd0);
            ST_TERM_B:   rd_addr = elem_addr(r_cidx, r_term, 2'd1);
            ST_MUL_DONE: rd_addr = elem_addr(r_cidx, r_term, 2'd2);
            ST_DET_A:    rd_addr = {2'b00, r_cidx[1:0]};
            default:     rd_addr = r_cnt;
        endcase
    end

    assign cof_addr = (r_state == ST_DET_A) ? r_cidx : {r_cnt[1:0], r_cnt[3:2]};
    assign elem_rd  = r_mat[rd_addr];
    assign cof_rd   = r_cof[cof_addr];

    assign mul_add  = r_b[0] ? r_m : '0;
    assign p_next   = (r_bit == 5'd31) ? r_p - mul_add : r_p + mul_add;
    assign acc_neg  = (r_phase == PH_SECOND) && (TermNeg[r_term] ^ r_cidx[2] ^ r_cidx[0]);
    assign acc_next = acc_neg ? r_acc - r_p : r_acc + r_p;

    assign rem_sh   = {r_rem[RemW-2:0], r_num[NW-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_dmag};
    assign rem_sub  = rem_sh - {1'b0, r_dmag};
    assign cof_mag  = cof_rd[CofW-1] ? (~cof_rd + 1'b1) : cof_rd;
    assign sat_limit = r_negr ? 32'h8000_0000 : 32'h7FFF_FFFF;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (i_valid && r_cnt == 4'd15) n_state = ST_TERM_A;
            end
            ST_TERM_A: n_state = ST_TERM_B;
            ST_TERM_B: n_state = ST_MUL;
            ST_MUL: begin
                if (r_bit == 5'd31) n_state = ST_MUL_DONE;
            end
            ST_MUL_DONE: begin
                unique case (r_phase)
                    PH_FIRST: n_state = ST_MUL;
                    PH_SECOND: begin
                        if (r_term == 3'd5 && r_cidx == 4'd15) n_state = ST_DET_A;
                        else                                    n_state = ST_TERM_A;
                    end
                    PH_DET: begin
                        if (r_cidx[1:0] == 2'd3) n_state = ST_DET_PREP;
                        else                     n_state = ST_DET_A;
                    end
                    default: n_state = ST_LOAD;
                endcase
            end
            ST_DET_A:    n_state = ST_MUL;
            ST_DET_PREP: n_state = ST_K_INIT;
            ST_K_INIT:   n_state = r_sing ? ST_OUT : ST_DIV;
            ST_DIV: begin
                if (r_dcnt == CntW'(NW - 1)) n_state = ST_FIN;
            end
            ST_FIN: n_state = ST_OUT;
            ST_OUT: begin
                if (!i_stall) n_state = (r_cnt == 4'd15) ? ST_LOAD : ST_K_INIT;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_stall       = (r_state != ST_LOAD);
        o_valid       = (r_state == ST_OUT);
        o_inv_element = r_val;
        o_position    = r_cnt;
        o_singular    = r_sing;
        o_saturated   = r_sat;
        o_last        = (r_cnt == 4'd15);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_LOAD: begin
                    if (i_valid) begin
                        r_mat[r_cnt] <= i_element;
                        r_cnt        <= r_cnt + 4'd1;
                        r_cidx       <= '0;
                        r_term       <= '0;
                        r_acc        <= '0;
                    end
                end
                ST_TERM_A: begin
                    r_m <= {{(AccW-ElemW){elem_rd[ElemW-1]}}, elem_rd};
                    r_p <= '0;
                end
                ST_TERM_B: begin
                    r_b     <= elem_rd;
                    r_bit   <= '0;
                    r_phase <= PH_FIRST;
                end
                ST_DET_A: begin
                    r_m     <= {{(AccW-CofW){cof_rd[CofW-1]}}, cof_rd};
                    r_p     <= '0;
                    r_b     <= elem_rd;
                    r_bit   <= '0;
                    r_phase <= PH_DET;
                end
                ST_MUL: begin
                    r_p   <= p_next;
                    r_m   <= {r_m[AccW-2:0], 1'b0};
                    r_b   <= {1'b0, r_b[ElemW-1:1]};
                    r_bit <= r_bit + 5'd1;
                end
                ST_MUL_DONE: begin
                    unique case (r_phase)
                        PH_FIRST: begin
                            r_m     <= r_p;
                            r_p     <= '0;
                            r_b     <= elem_rd;
                            r_bit   <= '0;
                            r_phase <= PH_SECOND;
                        end
                        PH_SECOND: begin
                            if (r_term == 3'd5) begin
                                r_cof[r_cidx] <= acc_next[CofW-1:0];
                                r_acc         <= '0;
                                r_term        <= '0;
                                r_cidx        <= r_cidx + 4'd1;
                            end else begin
                                r_acc  <= acc_next;
                                r_term <= r_term + 3'd1;
                            end
                        end
                        PH_DET: begin
                            r_acc  <= acc_next;
                            r_cidx <= r_cidx + 4'd1;
                        end
                        default: r_acc <= r_acc;
                    endcase
                end
                ST_DET_PREP: begin
                    r_dneg <= r_acc[AccW-1];
                    r_dmag <= r_acc[AccW-1] ? (~r_acc + 1'b1) : r_acc;
                    r_sing <= (r_acc == '0);
                end
                ST_K_INIT: begin
                    r_negr <= cof_rd[CofW-1] ^ r_dneg;
                    r_num  <= {cof_mag, {(2*FRAC_BITS){1'b0}}};
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_hi   <= 1'b0;
                    r_dcnt <= '0;
                    if (r_sing) begin
                        r_val <= '0;
                        r_sat <= 1'b0;
                    end
                end
                ST_DIV: begin
                    r_num  <= {r_num[NW-2:0], 1'b0};
                    r_rem  <= rem_ge ? rem_sub : rem_sh;
                    r_hi   <= r_hi | r_q[QW-1];
                    r_q    <= {r_q[QW-2:0], rem_ge};
                    r_dcnt <= r_dcnt + 1'b1;
                end
                ST_FIN: begin
                    if (r_hi || r_q > {1'b0, sat_limit}) begin
                        r_val <= sat_limit;
                        r_sat <= 1'b1;
                    end else begin
                        r_val <= r_negr ? (~r_q[31:0] + 32'd1) : r_q[31:0];
                        r_sat <= 1'b0;
                    end
                end
                ST_OUT: begin
                    if (!i_stall) r_cnt <= r_cnt + 4'd1;
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hdl/mat4ci_checker.sv */
// Port-level assertion checker for the 4x4 cofactor matrix inverse, with its bind
`include "assert_macros.svh"

module mat4ci_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic signed [31:0] i_element,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_inv_element,
    input logic        [3:0]  o_position,
    input logic               o_singular,
    input logic               o_saturated,
    input logic               o_last
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_inv_element) && $stable(o_position))
    `ASSERT_IMPLY(a_busy_emit, i_clk, i_rst_n, o_valid, o_stall)
    `ASSERT_IMPLY(a_sing_zero, i_clk, i_rst_n, o_valid && o_singular, o_inv_element == 32'sd0 && !o_saturated)
    `ASSERT_IMPLY(a_last_pos, i_clk, i_rst_n, o_valid, o_last == (o_position == 4'd15))
    `ASSERT_IMPLY(a_sat_val, i_clk, i_rst_n, o_valid && o_saturated, o_inv_element == 32'sh7FFF_FFFF || o_inv_element == 32'sh8000_0000)

endmodule

bind mat4_cofactor_inverse mat4ci_checker u_mat4ci_checker (.*);
